/* src/cbc_pkg.sv */
// cartridge bank controller package: item structs, opcodes, register indexes,
// datapath command struct and the rom size mask function; no dependencies
`default_nettype none

package cbc_pkg;

    localparam int BANK_BITS = 13;                 // 8 KB external ram bank
    localparam logic [2:0] ROM_CODE_MAX = 3'd6;    // 2 MB

    localparam logic [1:0] OP_REG_WR = 2'd0;
    localparam logic [1:0] OP_RAM_WR = 2'd1;
    localparam logic [1:0] OP_RAM_RD = 2'd2;

    localparam logic [1:0] CFG_ROM_SIZE = 2'd0;
    localparam logic [1:0] CFG_RAM_SIZE = 2'd1;

    localparam logic [1:0] RAM_NONE  = 2'd0;
    localparam logic [1:0] RAM_8KB   = 2'd1;
    localparam logic [1:0] RAM_32KB  = 2'd2;

    // register window select, bus_address[14:13]
    localparam logic [1:0] REG_RAM_EN  = 2'd0;
    localparam logic [1:0] REG_PRIMARY = 2'd1;
    localparam logic [1:0] REG_SECOND  = 2'd2;
    localparam logic [1:0] REG_MODE    = 2'd3;

    localparam logic [2:0] RAM_WINDOW_TOP = 3'b101; // 0xa000-0xbfff
    localparam logic [3:0] RAM_EN_KEY     = 4'hA;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [6:0] low_window_bank;
        logic [6:0] high_window_bank;
        logic [1:0] active_ram_bank;
        logic       ram_on;
        logic       advanced_mode;
        logic       bad_address;
    } t_out_item;

    typedef struct packed {
        logic capture;   // latch the accepted item
        logic execute;   // apply the latched item to state and ram
    } t_dp_cmd;

    // (2 << code) - 1, code above 6 treated as 6
    function automatic logic [6:0] rom_mask(input logic [2:0] code);
        logic [2:0] c;
        logic [7:0] m;
        c = (code > ROM_CODE_MAX) ? ROM_CODE_MAX : code;
        m = (8'd2 << c) - 8'd1;
        return m[6:0];
    endfunction

endpackage

`default_nettype wire

/* src/cbc_ctrl.sv */
// cartridge bank controller sequencer: accept, execute, respond
// depends on cbc_pkg
`default_nettype none

module cbc_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  wire            i_out_stall,
    output cbc_pkg::t_dp_cmd o_cmd
);
    import cbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_RESP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* src/cbc_datapath.sv */
// cartridge bank controller datapath: config registers, bank registers,
// bank mapping and external ram; depends on cbc_pkg
`default_nettype none

module cbc_datapath #(
    parameter int RAM_BYTES = 32768
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  cbc_pkg::t_dp_cmd   i_cmd,
    input  cbc_pkg::t_in_item  i_item,
    input  wire                i_cfg_we,
    input  wire  [1:0]         i_cfg_index,
    input  wire  [2:0]         i_cfg_data,
    output cbc_pkg::t_out_item o_item
);
    import cbc_pkg::*;

    localparam int AW = $clog2(RAM_BYTES);

    logic [2:0] r_rom_code;
    logic [1:0] r_ram_code;
    logic       r_ram_en, n_ram_en;
    logic       r_mode, n_mode;
    logic [4:0] r_primary, n_primary;
    logic [1:0] r_second, n_second;
    logic [6:0] r_low, n_low;
    logic [6:0] r_high, n_high;
    logic       r_bad, n_bad;
    logic       r_rd_keep;
    logic [7:0] r_rd_q;

    t_in_item   r_item;

    logic [7:0] mem [RAM_BYTES];

    logic [6:0] mask;
    logic [4:0] prim_new;
    logic       ram_ok;
    logic [1:0] ram_bank;
    logic [14:0] off_full;
    logic [AW-1:0] off;
    logic       is_reg, is_ram, ram_hit;

    assign mask     = rom_mask(r_rom_code);
    assign ram_ok   = ((r_ram_code == RAM_8KB) || (r_ram_code == RAM_32KB)) && r_ram_en;
    assign ram_bank = (r_mode && (r_ram_code == RAM_32KB)) ? r_second : 2'd0;
    // bank size is fixed at 8 KB; the user must keep the ram depth a power of two
    assign off_full = {ram_bank, r_item.bus_address[BANK_BITS-1:0]};
    assign off      = off_full[AW-1:0];

    assign is_reg  = (r_item.opcode == OP_REG_WR);
    assign is_ram  = (r_item.opcode == OP_RAM_WR) || (r_item.opcode == OP_RAM_RD);
    assign ram_hit = is_ram && (r_item.bus_address[15:13] == RAM_WINDOW_TOP);

    assign prim_new = r_item.write_byte[4:0] & mask[4:0];

    always_comb begin
        n_ram_en  = r_ram_en;
        n_mode    = r_mode;
        n_primary = r_primary;
        n_second  = r_second;
        n_low     = r_low;
        n_high    = r_high;
        n_bad     = 1'b0;
        if (is_reg) begin
            if (r_item.bus_address[15]) begin
                n_bad = 1'b1;
            end else begin
                case (r_item.bus_address[14:13])
                    REG_RAM_EN:  n_ram_en  = (r_item.write_byte[3:0] == RAM_EN_KEY);
                    REG_PRIMARY: n_primary = (prim_new == 5'd0) ? 5'd1 : prim_new;
                    REG_SECOND:  n_second  = r_item.write_byte[1:0];
                    REG_MODE:    n_mode    = r_item.write_byte[0];
                    default:     n_mode    = r_mode;
                endcase
                n_high = {n_second, n_primary} & mask;
                n_low  = n_mode ? ({n_second, 5'd0} & mask) : 7'd0;
            end
        end else if (is_ram && !ram_hit) begin
            n_bad = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_code <= 3'd0;
            r_ram_code <= RAM_NONE;
            r_ram_en   <= 1'b0;
            r_mode     <= 1'b0;
            r_primary  <= 5'd1;
            r_second   <= 2'd0;
            r_low      <= 7'd0;
            r_high     <= 7'd1;
            r_bad      <= 1'b0;
            r_rd_keep  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ROM_SIZE) begin
                    r_rom_code <= i_cfg_data;
                end else if (i_cfg_index == CFG_RAM_SIZE) begin
                    r_ram_code <= i_cfg_data[1:0];
                end
            end
            if (i_cmd.execute) begin
                r_ram_en  <= n_ram_en;
                r_mode    <= n_mode;
                r_primary <= n_primary;
                r_second  <= n_second;
                r_low     <= n_low;
                r_high    <= n_high;
                r_bad     <= n_bad;
                r_rd_keep <= ram_hit && ram_ok && (r_item.opcode == OP_RAM_RD);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && ram_hit && ram_ok && (r_item.opcode == OP_RAM_WR)) begin
            mem[off] <= r_item.write_byte;
        end
        if (i_cmd.execute) begin
            r_rd_q <= mem[off];
        end
    end

    assign o_item.read_byte        = r_rd_keep ? r_rd_q : 8'd0;
    assign o_item.low_window_bank  = r_low;
    assign o_item.high_window_bank = r_high;
    assign o_item.active_ram_bank  = ram_bank;
    assign o_item.ram_on           = r_ram_en;
    assign o_item.advanced_mode    = r_mode;
    assign o_item.bad_address      = r_bad;

endmodule

`default_nettype wire

/* src/cartridge_bank_controller.sv */
// Cartridge bank controller (MBC1 style). Each item is one bus access: a
// register write, an external ram write or an external ram read; each item
// gives exactly one result with the mapped rom banks, the ram bank, the
// enable and mode flags, read data and a bad-address flag. An item is
// accepted in the idle state and its result is offered in the respond state,
// after the execute state with the single-port ram access; no new item is
// taken until that result has been taken, and the result is held while
// stalled. RAM_BYTES sets the external ram depth and must be a power of two
// between 8 KB and 32 KB. The ram has no reset: reading a location never
// written returns whatever it holds. Configuration writes are always ready
// and must be made while no item is in flight.
// depends on cbc_pkg, cbc_ctrl, cbc_datapath
`default_nettype none

module cartridge_bank_controller #(
    parameter int RAM_BYTES = 32768
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  cbc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output cbc_pkg::t_out_item o_out_item,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [1:0]         i_cfg_index,
    input  wire  [2:0]         i_cfg_data
);
    import cbc_pkg::*;

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    cbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    cbc_datapath #(
        .RAM_BYTES (RAM_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_item      (o_out_item)
    );

    // a result is never offered while a new item could be taken
    a_resp_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result offered while input side open");

    // an accepted item shows its result in the respond state, after the execute state
    a_accept_to_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> ##1 o_out_valid)
        else $error("result missing after accepted item");

    // bad address or disabled ram never returns read data
    a_no_bad_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.bad_address || !o_out_item.ram_on))
        |-> (o_out_item.read_byte == 8'd0))
        else $error("read data with bad address or ram disabled");

endmodule

`default_nettype wire

/* verif/cartridge_bank_controller_test.sv */
// self-checking testbench for cartridge_bank_controller: directed and random bus accesses,
// with the bank state and cartridge ram tracked in the bench and every report checked
// depends on cbc_pkg and cartridge_bank_controller
`timescale 1ns / 100ps

module cartridge_bank_controller_test;

    import cbc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 5000;
    localparam int PHASES = 9;
    localparam int PHASE_ACCESSES = 133;
    // per-phase size codes, phase 0 in the low bits
    localparam logic [26:0] ROM_PLAN = {3'd6, 3'd4, 3'd2, 3'd5, 3'd1, 3'd3, 3'd7, 3'd6, 3'd0};
    localparam logic [17:0] RAM_PLAN = {2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2, 2'd2};

    typedef struct packed {
        logic [2:0] rom_code;
        logic [1:0] ram_code;
        logic       ram_en;
        logic       mode;
        logic [4:0] primary;
        logic [1:0] secondary;
        logic [6:0] low_bank;
        logic [6:0] high_bank;
    } t_bank_state;

    localparam t_bank_state BANK_RESET = {3'd0, RAM_NONE, 1'b0, 1'b0, 5'd1, 2'd0, 7'd0, 7'd1};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_item = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = CFG_ROM_SIZE;
    logic [2:0] cfg_data = 3'd0;
    logic       in_stall;
    logic       out_valid;
    t_out_item  out_item;
    logic       cfg_ready;

    t_in_item    pending_accesses[$];
    t_out_item   expected_reports[$];
    t_bank_state bank_state;
    t_bank_state planned_state;
    logic [7:0]  cart_ram [0:32767];
    bit          planned_written [0:32767];
    logic [7:0]  seen_byte;
    logic        seen_bad;
    t_out_item   want;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    cartridge_bank_controller DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [6:0] size_mask(input logic [2:0] code);
        logic [2:0] c;
        logic [7:0] m;
        c = (code > 3'd6) ? 3'd6 : code;
        m = (8'd2 << c) - 8'd1;
        return m[6:0];
    endfunction

    function automatic logic [1:0] ram_bank(input t_bank_state s);
        return (s.mode && s.ram_code == RAM_32KB) ? s.secondary : 2'd0;
    endfunction

    function automatic logic ram_live(input t_bank_state s);
        return (s.ram_code == RAM_8KB || s.ram_code == RAM_32KB) && s.ram_en;
    endfunction

    function automatic logic [14:0] ram_offset(input t_bank_state s, input logic [15:0] addr);
        return {ram_bank(s), addr[12:0]};
    endfunction

    function automatic logic access_is_bad(input t_in_item it);
        if (it.opcode == OP_REG_WR)
            return it.bus_address[15];
        if (it.opcode == OP_RAM_WR || it.opcode == OP_RAM_RD)
            return it.bus_address[15:13] != RAM_WINDOW_TOP;
        return 1'b0;
    endfunction

    // register write at a valid address, banks remapped with the current rom size
    function automatic t_bank_state reg_write(input t_bank_state s, input t_in_item it);
        logic [6:0] m;
        logic [4:0] b;
        m = size_mask(s.rom_code);
        case (it.bus_address[14:13])
            REG_RAM_EN: begin
                s.ram_en = (it.write_byte[3:0] == RAM_EN_KEY);
            end
            REG_PRIMARY: begin
                b = it.write_byte[4:0] & m[4:0];
                s.primary = (b == 5'd0) ? 5'd1 : b;
            end
            REG_SECOND: begin
                s.secondary = it.write_byte[1:0];
            end
            REG_MODE: begin
                s.mode = it.write_byte[0];
            end
            default: begin
                s.mode = s.mode;
            end
        endcase
        s.high_bank = {s.secondary, s.primary} & m;
        s.low_bank = s.mode ? ({s.secondary, 5'd0} & m) : 7'd0;
        return s;
    endfunction

    function automatic t_out_item bank_report(input t_bank_state s, input logic [7:0] rd,
                                              input logic bad);
        t_out_item r;
        r.read_byte = rd;
        r.low_window_bank = s.low_bank;
        r.high_window_bank = s.high_bank;
        r.active_ram_bank = ram_bank(s);
        r.ram_on = s.ram_en;
        r.advanced_mode = s.mode;
        r.bad_address = bad;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", field, exp_val, act_val);
            mismatches++;
        end
    endtask

    // queues one access; a live ram read of a byte never written becomes a write
    task automatic queue_access(input logic [1:0] op, input logic [15:0] addr,
                                input logic [7:0] data);
        t_in_item it;
        logic [14:0] off;
        logic hit;
        it.opcode = op;
        it.bus_address = addr;
        it.write_byte = data;
        hit = !access_is_bad(it) && (op == OP_RAM_WR || op == OP_RAM_RD)
              && ram_live(planned_state);
        off = ram_offset(planned_state, addr);
        if (hit && op == OP_RAM_RD && !planned_written[off])
            it.opcode = OP_RAM_WR;
        if (hit && it.opcode == OP_RAM_WR)
            planned_written[off] = 1'b1;
        if (op == OP_REG_WR && !access_is_bad(it))
            planned_state = reg_write(planned_state, it);
        pending_accesses.push_back(it);
    endtask

    task automatic queue_random(input int count);
        int pick;
        logic [1:0] op;
        logic [15:0] addr;
        logic [7:0] data;
        logic [2:0] win;
        repeat (count) begin
            pick = $urandom_range(99);
            data = 8'($urandom);
            if (pick < 36) begin
                op = OP_REG_WR;
                addr = {1'b0, 15'($urandom)};
                // keep ram enabled most of the time
                if (addr[14:13] == REG_RAM_EN && $urandom_range(3) != 0)
                    data[3:0] = RAM_EN_KEY;
                if ($urandom_range(19) == 0)
                    addr[15] = 1'b1;
            end else if (pick < 95) begin
                op = (pick < 62) ? OP_RAM_WR : OP_RAM_RD;
                // small address pool at both ends of the bank so reads hit written bytes
                addr = {RAM_WINDOW_TOP, ($urandom_range(1) != 0) ? 8'hFF : 8'h00,
                        5'($urandom)};
                if ($urandom_range(7) == 0)
                    addr[12:0] = 13'($urandom);
                if ($urandom_range(19) == 0) begin
                    do win = 3'($urandom); while (win == RAM_WINDOW_TOP);
                    addr[15:13] = win;
                end
            end else begin
                op = OP_UNUSED;
                addr = 16'($urandom);
            end
            queue_access(op, addr, data);
        end
    endtask

    task automatic write_config(input logic [1:0] idx, input logic [2:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ROM_SIZE) begin
            bank_state.rom_code = val;
            planned_state.rom_code = val;
        end else begin
            bank_state.ram_code = val[1:0];
            planned_state.ram_code = val[1:0];
        end
    endtask

    task automatic wait_idle();
        while (pending_accesses.size() != 0 || in_valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // driver: predicts each accepted item, then offers the next one
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                seen_bad = access_is_bad(in_item);
                seen_byte = 8'd0;
                if (!seen_bad && in_item.opcode == OP_REG_WR) begin
                    bank_state = reg_write(bank_state, in_item);
                end else if (!seen_bad && ram_live(bank_state)
                             && (in_item.opcode == OP_RAM_WR || in_item.opcode == OP_RAM_RD)) begin
                    if (in_item.opcode == OP_RAM_WR)
                        cart_ram[ram_offset(bank_state, in_item.bus_address)] = in_item.write_byte;
                    else
                        seen_byte = cart_ram[ram_offset(bank_state, in_item.bus_address)];
                end
                expected_reports.push_back(bank_report(bank_state, seen_byte, seen_bad));
            end
            if (!in_valid || !in_stall) begin
                if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_item <= pending_accesses.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("report arrived with no item outstanding");
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("read_byte", want.read_byte, out_item.read_byte);
                    check_field("low_window_bank", 8'(want.low_window_bank),
                                8'(out_item.low_window_bank));
                    check_field("high_window_bank", 8'(want.high_window_bank),
                                8'(out_item.high_window_bank));
                    check_field("active_ram_bank", 8'(want.active_ram_bank),
                                8'(out_item.active_ram_bank));
                    check_field("ram_on", 8'(want.ram_on), 8'(out_item.ram_on));
                    check_field("advanced_mode", 8'(want.advanced_mode),
                                8'(out_item.advanced_mode));
                    check_field("bad_address", 8'(want.bad_address),
                                8'(out_item.bad_address));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase;
        bank_state = BANK_RESET;
        planned_state = BANK_RESET;
        send_idle_pct = 31;
        recv_stall_pct = 81;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        write_config(CFG_ROM_SIZE, 3'd6);
        write_config(CFG_RAM_SIZE, {1'b0, RAM_32KB});
        queue_access(OP_REG_WR, 16'h0000, 8'h0A);
        queue_access(OP_RAM_WR, 16'hA000, 8'hFF);
        queue_access(OP_RAM_WR, 16'hBFFF, 8'h00);
        queue_access(OP_RAM_RD, 16'hA000, 8'h00);
        queue_access(OP_RAM_RD, 16'hBFFF, 8'hFF);
        queue_access(OP_REG_WR, 16'h2000, 8'h00);   // primary bank 0 reads as 1
        queue_access(OP_REG_WR, 16'h3FFF, 8'hFF);
        queue_access(OP_REG_WR, 16'h4000, 8'hFF);
        queue_access(OP_REG_WR, 16'h7FFF, 8'h01);   // ram mode, bank 3
        queue_access(OP_RAM_WR, 16'hA123, 8'h5A);
        queue_access(OP_RAM_RD, 16'hA123, 8'h00);
        queue_access(OP_RAM_RD, 16'h9FFF, 8'h00);
        queue_access(OP_RAM_WR, 16'hC000, 8'hA5);
        queue_access(OP_REG_WR, 16'h8000, 8'h0A);
        queue_access(OP_REG_WR, 16'hFFFF, 8'hFF);
        queue_access(OP_UNUSED, 16'hA000, 8'h55);
        queue_access(OP_REG_WR, 16'h6000, 8'h00);
        queue_access(OP_RAM_RD, 16'hA000, 8'h00);
        queue_access(OP_REG_WR, 16'h1FFF, 8'h0B);   // disables ram
        queue_access(OP_RAM_RD, 16'hA000, 8'h00);
        queue_access(OP_RAM_WR, 16'hA001, 8'h77);

        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            if (phase == 3) begin
                send_idle_pct = 81;
                recv_stall_pct = 31;
            end else if (phase == 6) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            write_config(CFG_ROM_SIZE, ROM_PLAN[3*phase +: 3]);
            write_config(CFG_RAM_SIZE, {1'b0, RAM_PLAN[2*phase +: 2]});
            queue_access(OP_REG_WR, 16'($urandom_range(16'h1FFF)), {4'($urandom), RAM_EN_KEY});
            queue_random(PHASE_ACCESSES);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
src/cbc_pkg.sv
src/cbc_ctrl.sv
src/cbc_datapath.sv
src/cartridge_bank_controller.sv
verif/cartridge_bank_controller_test.sv
